>>> design/sbms_pkg.sv
// ----------------------------------------------------------------------------
// Shared buffer multi stack package
// Sizes, codes and beat types shared by the shared buffer multi stack block.
// ----------------------------------------------------------------------------
package sbms_pkg;

   localparam int STORE_DEPTH = 128;
   localparam int NUM_LISTS   = 4;
   localparam int WORD_WIDTH  = 32;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W  = $clog2(NUM_LISTS);
   localparam int ID_W   = 2;
   localparam int LEN_W  = 8;

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [ID_W-1:0]       list_id;
      logic [WORD_WIDTH-1:0] push_word;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] pop_word;
      status_type            status;
      logic [LEN_W-1:0]      list_length;
   } rsp_type;

   // Work plan for the operation held by the sequencer, derived from the directory.
   typedef struct packed {
      logic              push_ok;
      logic              pop_ok;
      logic              pop_hit;
      logic [ADDR_W-1:0] pos;
      logic [CNT_W-1:0]  used;
      status_type        status;
      logic [CNT_W-1:0]  len_after;
   } plan_type;

endpackage

>>> design/sbms_ram.sv
// ----------------------------------------------------------------------------
// Shared buffer multi stack word memory
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbms_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/sbms_dir.sv
// ----------------------------------------------------------------------------
// Shared buffer multi stack directory
// Holds each list's start and count and the used total, plans the operation
// on the held request and applies its bookkeeping when the sequencer commits.
// ----------------------------------------------------------------------------
module sbms_dir import sbms_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  op,
   input  logic     commit,
   output plan_type plan
);

   logic [ADDR_W-1:0] start_ff [NUM_LISTS];
   logic [ADDR_W-1:0] start_in [NUM_LISTS];
   logic [CNT_W-1:0]  cnt_ff   [NUM_LISTS];
   logic [CNT_W-1:0]  cnt_in   [NUM_LISTS];
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  used_in;

   logic              id_ok;
   logic [IDX_W-1:0]  idx;
   logic [ADDR_W-1:0] cur_start;
   logic [CNT_W-1:0]  cur_cnt;
   logic [ADDR_W-1:0] eff_start;
   logic [CNT_W:0]    end_sum;
   logic [CNT_W:0]    end_clip;
   logic [CNT_W:0]    last_sum;
   logic              full;

   always_comb begin
      id_ok     = (int'(op.list_id) < NUM_LISTS);
      idx       = op.list_id[IDX_W-1:0];
      cur_start = start_ff[idx];
      cur_cnt   = cnt_ff[idx];
      full      = (used_ff >= CNT_W'(STORE_DEPTH));
      // An empty list restarts at the end of the used region.
      eff_start = (cur_cnt == '0) ? used_ff[ADDR_W-1:0] : cur_start;
      end_sum   = (CNT_W+1)'(eff_start) + (CNT_W+1)'(cur_cnt);
      end_clip  = (end_sum > (CNT_W+1)'(used_ff)) ? (CNT_W+1)'(used_ff) : end_sum;
      last_sum  = (CNT_W+1)'(cur_start) + (CNT_W+1)'(cur_cnt) - (CNT_W+1)'(1);

      plan.push_ok = id_ok && (op.cmd == CMD_PUSH) && !full;
      plan.pop_ok  = id_ok && (op.cmd == CMD_POP) && (cur_cnt != '0);
      plan.pop_hit = (last_sum < (CNT_W+1)'(used_ff));
      plan.pos     = (op.cmd == CMD_PUSH) ? end_clip[ADDR_W-1:0] : last_sum[ADDR_W-1:0];
      plan.used    = used_ff;

      plan.status    = STATUS_DONE;
      plan.len_after = '0;
      if (id_ok) begin
         if (op.cmd == CMD_PUSH) begin
            if (full) begin
               plan.status    = STATUS_FULL;
               plan.len_after = cur_cnt;
            end else begin
               plan.len_after = cur_cnt + CNT_W'(1);
            end
         end else if (cur_cnt == '0) begin
            plan.status = STATUS_EMPTY;
         end else begin
            plan.len_after = cur_cnt - CNT_W'(1);
         end
      end

      start_in = start_ff;
      cnt_in   = cnt_ff;
      used_in  = used_ff;
      if (commit && plan.push_ok) begin
         for (int j = 0; j < NUM_LISTS; j++) begin
            if (j != int'(idx) && start_ff[j] > eff_start) begin
               start_in[j] = start_ff[j] + ADDR_W'(1);
            end
         end
         start_in[idx] = eff_start;
         cnt_in[idx]   = cur_cnt + CNT_W'(1);
         used_in       = used_ff + CNT_W'(1);
      end else if (commit && plan.pop_ok) begin
         for (int j = 0; j < NUM_LISTS; j++) begin
            if (j != int'(idx) && start_ff[j] > cur_start && start_ff[j] != '0) begin
               start_in[j] = start_ff[j] - ADDR_W'(1);
            end
         end
         cnt_in[idx] = cur_cnt - CNT_W'(1);
         if (used_ff != '0) begin
            used_in = used_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_LISTS; j++) begin
            start_ff[j] <= '0;
            cnt_ff[j]   <= '0;
         end
         used_ff <= '0;
      end else begin
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
      end
   end

endmodule

>>> design/shared_buffer_multi_stack.sv
// ----------------------------------------------------------------------------
// Shared buffer multi stack
// Four stacks packed end to end in one shared word memory, with push and pop.
// ----------------------------------------------------------------------------
// Each request beat is a push or a pop on one list and yields exactly one
// response beat. The lists share one memory, so a push opens a gap after the
// list's last entry by moving every later word up one place, and a pop closes
// the gap by moving them down; this goes one word per cycle through the single
// write port of the word memory. A push moves each word at or above its
// position up, from the top down, then writes the new word there; a pop
// first reads the popped entry, then moves each word stored above it down.
// The slowest case is a pop of the lowest entry of a full memory. A pop on
// an empty list or a push to a full memory goes straight to the response
// without touching the memory. The response beat is loaded as the block
// returns to idle, where the next request is taken. One item is worked on
// at a time; a finished response waits in an output register, and the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack import sbms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_beat,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_beat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_PUSH,
      ST_POP,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   req_type               op_ff, op_in;
   logic [CNT_W-1:0]      cur_ff, cur_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic                  first_ff, first_in;
   logic [WORD_WIDTH-1:0] pop_word_ff, pop_word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_beat_ff, rsp_beat_in;

   plan_type              plan;
   logic                  commit;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;

   sbms_dir u_dir (
      .clock  (clock),
      .reset  (reset),
      .op     (op_ff),
      .commit (commit),
      .plan   (plan)
   );

   sbms_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (WORD_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      used_in      = used_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      first_in     = first_ff;
      pop_word_in  = pop_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      commit       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_beat;
               state_in = ST_PLAN;
            end
         end

         ST_PLAN: begin
            pend_in     = 1'b0;
            first_in    = 1'b0;
            pop_word_in = '0;
            pos_in      = plan.pos;
            used_in     = plan.used;
            if (plan.push_ok) begin
               cur_in   = plan.used;
               state_in = ST_PUSH;
            end else if (plan.pop_ok) begin
               // A last entry outside the used region leaves nothing to read.
               cur_in   = plan.pop_hit ? CNT_W'(plan.pos) : plan.used;
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end

         // Words move up from the top down: read below the cursor, write at it.
         ST_PUSH: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (cur_ff > CNT_W'(pos_ff)) begin
               rd_en        = 1'b1;
               rd_addr      = ADDR_W'(cur_ff - CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = cur_ff[ADDR_W-1:0];
               cur_in       = cur_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff;
                  wr_data  = op_ff.push_word;
                  state_in = ST_DONE;
               end
            end
         end

         // The first read returns the popped word; later words move down by one.
         ST_POP: begin
            if (pend_ff) begin
               if (first_ff) begin
                  pop_word_in = rd_data;
               end else begin
                  wr_en = 1'b1;
               end
            end
            if (cur_ff < used_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cur_ff[ADDR_W-1:0] - ADDR_W'(1);
               first_in     = (cur_ff == CNT_W'(pos_ff));
               cur_in       = cur_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               commit                  = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_beat_in.pop_word    = pop_word_ff;
               rsp_beat_in.status      = plan.status;
               rsp_beat_in.list_length = LEN_W'(plan.len_after);
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      used_ff      <= used_in;
      pend_addr_ff <= pend_addr_in;
      pop_word_ff  <= pop_word_in;
      rsp_beat_ff  <= rsp_beat_in;
   end

endmodule
